### design/ecal_pkg.sv
// ecal_pkg: shared types, constants and tables for the epoch-to-calendar converter
`timescale 1ns / 1ps
`default_nettype none

package ecal_pkg;

  // field widths
  localparam int unsigned EpochW = 32;
  localparam int unsigned SecW   = 6;
  localparam int unsigned MinW   = 6;
  localparam int unsigned HourW  = 5;
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonW   = 4;
  localparam int unsigned YearW  = 12;
  localparam int unsigned WdayW  = 3;

  // datapath widths
  localparam int unsigned RemW   = 16;
  localparam int unsigned MulW   = EpochW;
  localparam int unsigned HoursW = 21;
  localparam int unsigned DoyW   = 9;

  // calendar constants
  localparam logic [RemW-1:0]   SECS_PER_MIN     = RemW'(60);
  localparam logic [RemW-1:0]   MINS_PER_HOUR    = RemW'(60);
  localparam logic [RemW-1:0]   HOURS_PER_DAY    = RemW'(24);
  localparam logic [RemW-1:0]   DAYS_PER_WEEK    = RemW'(7);
  localparam logic [RemW-1:0]   HOURS_PER_QUAD   = RemW'(1461 * 24);
  localparam logic [RemW-1:0]   HOURS_PER_COMMON = RemW'(365 * 24);
  localparam logic [RemW-1:0]   HOURS_PER_LEAP   = RemW'(366 * 24);
  localparam logic [YearW-1:0]  EPOCH_YEAR       = YearW'(1970);
  localparam logic [EpochW-1:0] EPOCH_WEEKDAY    = EpochW'(4);
  localparam logic [DoyW-1:0]   LEAP_DAY_DOY     = DoyW'(60);
  localparam logic [MonW-1:0]   MONTH_FEB        = MonW'(2);
  localparam logic [DoyW-1:0]   LEAP_DAY_DOM     = DoyW'(29);
  localparam logic [MonW-1:0]   MONTH_LAST_IDX   = MonW'(11);

  // reciprocal multipliers, rounded up; quotient is the product shifted right
  // sixty and day are exact for any 32-bit dividend, week below 2^30,
  // quad below 2^21 hours
  localparam int unsigned     SHR_SIXTY = 37;
  localparam int unsigned     SHR_DAY   = 36;
  localparam int unsigned     SHR_WEEK  = 32;
  localparam int unsigned     SHR_QUAD  = 37;
  localparam logic [MulW-1:0] RCP_SIXTY = MulW'(((64'd1 << SHR_SIXTY) + 64'd59) / 64'd60);
  localparam logic [MulW-1:0] RCP_DAY   = MulW'(((64'd1 << SHR_DAY) + 64'd23) / 64'd24);
  localparam logic [MulW-1:0] RCP_WEEK  = MulW'(((64'd1 << SHR_WEEK) + 64'd6) / 64'd7);
  localparam logic [MulW-1:0] RCP_QUAD  =
    MulW'(((64'd1 << SHR_QUAD) + 64'd35063) / 64'd35064);

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_e;

  // which constant division is running
  typedef enum logic [2:0] {
    DV_SEC,
    DV_MIN,
    DV_HOUR,
    DV_WDAY,
    DV_QUAD,
    DV_DAY
  } div_op_e;

  // shared multiply-subtract unit: prod = a * b, diff = c - low half of prod
  typedef struct packed {
    logic [MulW-1:0] a;
    logic [MulW-1:0] b;
    logic [MulW-1:0] c;
  } alu_req_t;

  typedef struct packed {
    logic [2*MulW-1:0] prod;
    logic [MulW-1:0]   diff;
    logic              ge;
    logic              gt;
  } alu_rsp_t;

  // divisor for each division step
  function automatic logic [RemW-1:0] divisor(input div_op_e op);
    logic [RemW-1:0] d;
    case (op)
      DV_SEC:  d = SECS_PER_MIN;
      DV_MIN:  d = MINS_PER_HOUR;
      DV_HOUR: d = HOURS_PER_DAY;
      DV_WDAY: d = DAYS_PER_WEEK;
      DV_QUAD: d = HOURS_PER_QUAD;
      DV_DAY:  d = HOURS_PER_DAY;
      default: d = HOURS_PER_DAY;
    endcase
    return d;
  endfunction

  // reciprocal multiplier for each division step
  function automatic logic [MulW-1:0] reciprocal(input div_op_e op);
    logic [MulW-1:0] m;
    case (op)
      DV_SEC, DV_MIN:  m = RCP_SIXTY;
      DV_HOUR, DV_DAY: m = RCP_DAY;
      DV_WDAY:         m = RCP_WEEK;
      DV_QUAD:         m = RCP_QUAD;
      default:         m = RCP_DAY;
    endcase
    return m;
  endfunction

  // days in month, index 0 is january, february without leap day
  function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] idx);
    logic [DayW-1:0] len;
    case (idx)
      4'd1:                      len = DayW'(28);
      4'd3, 4'd5, 4'd8, 4'd10:   len = DayW'(30);
      default:                   len = DayW'(31);
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

### design/ecal_if.sv
// ecal_if: request channels for epoch seconds in and calendar fields out
`timescale 1ns / 1ps
`default_nettype none

interface ecal_in_if;
  import ecal_pkg::*;

  logic              valid;
  logic              ready;
  logic [EpochW-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink (input valid, input epoch_seconds, output ready);
endinterface

interface ecal_out_if;
  import ecal_pkg::*;

  logic             valid;
  logic             ready;
  logic [SecW-1:0]  second;
  logic [MinW-1:0]  minute;
  logic [HourW-1:0] hour;
  logic [DayW-1:0]  day_of_month;
  logic [MonW-1:0]  month;
  logic [YearW-1:0] year;
  logic [WdayW-1:0] weekday;

  modport source (output valid, output second, output minute, output hour,
                  output day_of_month, output month, output year, output weekday,
                  input ready);
  modport sink (input valid, input second, input minute, input hour,
                input day_of_month, input month, input year, input weekday,
                output ready);
endinterface

`default_nettype wire

### design/ecal_alu.sv
// ecal_alu: shared multiply, subtract and compare unit used by the division, year and month steps of the sequencer
`timescale 1ns / 1ps
`default_nettype none

module ecal_alu (
  input  ecal_pkg::alu_req_t req_i,
  output ecal_pkg::alu_rsp_t rsp_o
);
  import ecal_pkg::*;

  logic [2*MulW-1:0] prod;

  // one multiply, then subtract and compare against its low half
  assign prod = (2*MulW)'(req_i.a) * (2*MulW)'(req_i.b);

  always_comb begin
    rsp_o.prod = prod;
    rsp_o.diff = req_i.c - prod[MulW-1:0];
    rsp_o.ge   = (req_i.c >= prod[MulW-1:0]);
    rsp_o.gt   = (req_i.c > prod[MulW-1:0]);
  end

endmodule

`default_nettype wire

### design/epoch_seconds_to_calendar_unit.sv
// epoch_seconds_to_calendar_unit: seconds since 1970-01-01 to calendar date and time
//
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into
// second, minute, hour, day of month, month, year and weekday (0 is Sunday).
// Leap years follow the divisible-by-four rule, so results match the civil
// calendar through 2099 and treat 2100 as a leap year. One request is worked at
// a time: a single multiply-subtract unit performs six divisions by constants
// (60, 60, 24, 7, hours per four years, 24) by reciprocal multiplication, each as
// a quotient step followed by a remainder step. Between the fifth and the sixth
// division it peels up to three whole years off the hours left, and after the
// sixth it walks up to eleven months, one step per cycle. The finished result
// waits until the output register is free and then sits in that register until
// taken; the input side is ready again once the result has been registered.
`timescale 1ns / 1ps
`default_nettype none

module epoch_seconds_to_calendar_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  ecal_in_if.sink           in_i,
  ecal_out_if.source        out_o
);
  import ecal_pkg::*;

  state_e            state_q, state_d;
  div_op_e           op_q, op_d;
  logic              phase_q, phase_d;
  logic [EpochW-1:0] num_q, num_d;
  logic [EpochW-1:0] quot_q, quot_d;
  logic [RemW-1:0]   rem_q, rem_d;
  logic [HoursW-1:0] hours_q, hours_d;
  logic [SecW-1:0]   sec_q, sec_d;
  logic [MinW-1:0]   min_q, min_d;
  logic [HourW-1:0]  hour_q, hour_d;
  logic [WdayW-1:0]  wday_q, wday_d;
  logic [YearW-1:0]  year_q, year_d;
  logic [DoyW-1:0]   day_q, day_d;
  logic [MonW-1:0]   mon_q, mon_d;

  logic              out_valid_q, out_valid_d;
  logic [SecW-1:0]   out_sec_q, out_sec_d;
  logic [MinW-1:0]   out_min_q, out_min_d;
  logic [HourW-1:0]  out_hour_q, out_hour_d;
  logic [DayW-1:0]   out_day_q, out_day_d;
  logic [MonW-1:0]   out_mon_q, out_mon_d;
  logic [YearW-1:0]  out_year_q, out_year_d;
  logic [WdayW-1:0]  out_wday_q, out_wday_d;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  logic              leap;
  logic [EpochW-1:0] quot;
  logic [DoyW-1:0]   doy;

  // shared arithmetic unit
  ecal_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign leap = (year_q[1:0] == 2'b00);

  // operand select for the shared unit
  always_comb begin
    alu_req.a = '0;
    alu_req.b = '0;
    alu_req.c = '0;
    case (state_q)
      ST_DIV: begin
        if (!phase_q) begin
          alu_req.a = num_q;
          alu_req.b = reciprocal(op_q);
        end else begin
          alu_req.a = quot_q;
          alu_req.b = {{(MulW-RemW){1'b0}}, divisor(op_q)};
          alu_req.c = num_q;
        end
      end
      ST_YEAR: begin
        alu_req.a = MulW'(1);
        alu_req.b = {{(MulW-RemW){1'b0}}, (leap ? HOURS_PER_LEAP : HOURS_PER_COMMON)};
        alu_req.c = {{(MulW-RemW){1'b0}}, rem_q};
      end
      ST_MONTH: begin
        alu_req.a = MulW'(1);
        alu_req.b = {{(MulW-DayW){1'b0}}, month_len(mon_q)};
        alu_req.c = {{(MulW-DoyW){1'b0}}, day_q};
      end
      default: begin
        alu_req.a = '0;
        alu_req.b = '0;
        alu_req.c = '0;
      end
    endcase
  end

  // quotient: upper part of the reciprocal product
  always_comb begin
    case (op_q)
      DV_SEC, DV_MIN:  quot = EpochW'(alu_rsp.prod[2*MulW-1:SHR_SIXTY]);
      DV_HOUR, DV_DAY: quot = EpochW'(alu_rsp.prod[2*MulW-1:SHR_DAY]);
      DV_WDAY:         quot = EpochW'(alu_rsp.prod[2*MulW-1:SHR_WEEK]);
      DV_QUAD:         quot = EpochW'(alu_rsp.prod[2*MulW-1:SHR_QUAD]);
      default:         quot = '0;
    endcase
  end

  assign doy = quot_q[DoyW-1:0] + DoyW'(1);

  // sequencer: next state and datapath updates
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    phase_d     = phase_q;
    num_d       = num_q;
    quot_d      = quot_q;
    rem_d       = rem_q;
    hours_d     = hours_q;
    sec_d       = sec_q;
    min_d       = min_q;
    hour_d      = hour_q;
    wday_d      = wday_q;
    year_d      = year_q;
    day_d       = day_q;
    mon_d       = mon_q;
    out_valid_d = out_valid_q;
    out_sec_d   = out_sec_q;
    out_min_d   = out_min_q;
    out_hour_d  = out_hour_q;
    out_day_d   = out_day_q;
    out_mon_d   = out_mon_q;
    out_year_d  = out_year_q;
    out_wday_d  = out_wday_q;

    // result taken downstream
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          num_d   = in_i.epoch_seconds;
          phase_d = 1'b0;
          op_d    = DV_SEC;
          state_d = ST_DIV;
        end
      end

      // quotient cycle, then remainder cycle
      ST_DIV: begin
        if (!phase_q) begin
          quot_d  = quot;
          phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          case (op_q)
            DV_SEC: begin
              sec_d = alu_rsp.diff[SecW-1:0];
              num_d = quot_q;
              op_d  = DV_MIN;
            end
            DV_MIN: begin
              min_d   = alu_rsp.diff[MinW-1:0];
              hours_d = quot_q[HoursW-1:0];
              num_d   = quot_q;
              op_d    = DV_HOUR;
            end
            DV_HOUR: begin
              hour_d = alu_rsp.diff[HourW-1:0];
              num_d  = quot_q + EPOCH_WEEKDAY;
              op_d   = DV_WDAY;
            end
            DV_WDAY: begin
              wday_d = alu_rsp.diff[WdayW-1:0];
              num_d  = {{(EpochW-HoursW){1'b0}}, hours_q};
              op_d   = DV_QUAD;
            end
            DV_QUAD: begin
              year_d  = EPOCH_YEAR + {quot_q[YearW-3:0], 2'b00};
              rem_d   = alu_rsp.diff[RemW-1:0];
              state_d = ST_YEAR;
            end
            DV_DAY: begin
              if (leap && (doy == LEAP_DAY_DOY)) begin
                mon_d   = MONTH_FEB;
                day_d   = LEAP_DAY_DOM;
                state_d = ST_DONE;
              end else begin
                day_d   = (leap && (doy > LEAP_DAY_DOY)) ? (doy - DoyW'(1)) : doy;
                mon_d   = '0;
                state_d = ST_MONTH;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      // peel whole years off the hours left in the four-year span
      ST_YEAR: begin
        if (alu_rsp.ge) begin
          rem_d  = alu_rsp.diff[RemW-1:0];
          year_d = year_q + YearW'(1);
        end else begin
          num_d   = {{(EpochW-RemW){1'b0}}, rem_q};
          phase_d = 1'b0;
          op_d    = DV_DAY;
          state_d = ST_DIV;
        end
      end

      // walk the month-length table
      ST_MONTH: begin
        mon_d = mon_q + MonW'(1);
        if ((mon_q < MONTH_LAST_IDX) && alu_rsp.gt) begin
          day_d = alu_rsp.diff[DoyW-1:0];
        end else begin
          state_d = ST_DONE;
        end
      end

      // hand over to the output register once it is free
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_sec_d   = sec_q;
          out_min_d   = min_q;
          out_hour_d  = hour_q;
          out_day_d   = day_q[DayW-1:0];
          out_mon_d   = mon_q;
          out_year_d  = year_q;
          out_wday_d  = wday_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      op_q        <= DV_SEC;
      phase_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      op_q        <= op_d;
      phase_q     <= phase_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    num_q      <= num_d;
    quot_q     <= quot_d;
    rem_q      <= rem_d;
    hours_q    <= hours_d;
    sec_q      <= sec_d;
    min_q      <= min_d;
    hour_q     <= hour_d;
    wday_q     <= wday_d;
    year_q     <= year_d;
    day_q      <= day_d;
    mon_q      <= mon_d;
    out_sec_q  <= out_sec_d;
    out_min_q  <= out_min_d;
    out_hour_q <= out_hour_d;
    out_day_q  <= out_day_d;
    out_mon_q  <= out_mon_d;
    out_year_q <= out_year_d;
    out_wday_q <= out_wday_d;
  end

  // channel outputs
  assign in_i.ready         = (state_q == ST_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.second       = out_sec_q;
  assign out_o.minute       = out_min_q;
  assign out_o.hour         = out_hour_q;
  assign out_o.day_of_month = out_day_q;
  assign out_o.month        = out_mon_q;
  assign out_o.year         = out_year_q;
  assign out_o.weekday      = out_wday_q;

  // a quotient cycle is always followed by its remainder cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && !phase_q |=> (state_q == ST_DIV) && phase_q)
    else $error("division remainder cycle skipped");

  // year stepping starts a fresh division and stays inside the span
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_YEAR) |-> !phase_q && (rem_q < HOURS_PER_QUAD))
    else $error("year stepping out of range");

  // month walk stays inside the table with a positive day
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MONTH) |-> (mon_q <= MONTH_LAST_IDX) && (day_q != '0))
    else $error("month walk out of range");

  // a delivered result carries a legal month, day and hour
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_mon_q >= MonW'(1)) && (out_mon_q <= MonW'(12))
                    && (out_day_q != '0) && (out_hour_q < HourW'(24)))
    else $error("result fields out of range");

  // no new request while a conversion is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_i.ready)
    else $error("input ready while busy");

endmodule

`default_nettype wire
